// File: src/lqr_pkg.sv
package lqr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int PSEC_W = 17;
  localparam int PREC_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W = 72;
  localparam int PROD_W = 64;

  localparam logic signed [DATA_W-1:0] TILT_LIMIT =
      DATA_W'(((64'sd61 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam logic signed [DATA_W-1:0] SPEED_LIMIT =
      DATA_W'(((64'sd2 <<< FRAC_BITS) + 64'sd5) / 64'sd10);

  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_ENABLE   = 2'd1;
  localparam logic [1:0] OP_DISABLE  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SECONDS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_RECIPROCAL = 3'd7;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] wheel_speed;
    logic signed [DATA_W-1:0] pitch_angle;
    logic signed [DATA_W-1:0] pitch_rate;
    logic signed [DATA_W-1:0] yaw_rate;
    logic signed [DATA_W-1:0] speed_target;
    logic signed [DATA_W-1:0] heading_target;
  } sample_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [DATA_W-1:0] drive_left;
    logic signed [DATA_W-1:0] drive_right;
    logic                    tilt_fault;
    logic                    reset_distance;
  } result_t;

  // Datapath steps issued by the controller.
  localparam logic [3:0] STEP_LOAD   = 4'd0;
  localparam logic [3:0] STEP_DISP   = 4'd1;
  localparam logic [3:0] STEP_HEAD   = 4'd2;
  localparam logic [3:0] STEP_HERR   = 4'd3;
  localparam logic [3:0] STEP_DERIV  = 4'd4;
  localparam logic [3:0] STEP_MAC0   = 4'd5;
  localparam logic [3:0] STEP_MAC1   = 4'd6;
  localparam logic [3:0] STEP_MAC2   = 4'd7;
  localparam logic [3:0] STEP_MAC3   = 4'd8;
  localparam logic [3:0] STEP_MAC4   = 4'd9;
  localparam logic [3:0] STEP_MAC5   = 4'd10;
  localparam logic [3:0] STEP_FINISH = 4'd11;
  localparam logic [3:0] STEP_IDLE   = 4'd12;

  typedef struct packed {
    logic       take;
    logic [3:0] step;
    logic       clear_sums;
  } dp_cmd_t;

  typedef struct packed {
    logic tilt;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

endpackage

// File: src/lqr_if.sv
interface lqr_sample_if;
  logic valid;
  logic ready;
  lqr_pkg::sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lqr_result_if;
  logic valid;
  logic ready;
  lqr_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lqr_cfg_if;
  logic valid;
  logic ready;
  logic [lqr_pkg::CFG_IDX_W-1:0] index;
  logic [lqr_pkg::DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/lqr_datapath.sv
module lqr_datapath (
  input  logic                   clk,
  input  logic                   cfg_we,
  input  logic [lqr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lqr_pkg::DATA_W-1:0]    cfg_data,
  input  logic                   rst,
  input  lqr_pkg::sample_t       sample,
  input  lqr_pkg::dp_cmd_t       cmd,
  output lqr_pkg::dp_status_t    status,
  output logic signed [lqr_pkg::DATA_W-1:0] drive_left,
  output logic signed [lqr_pkg::DATA_W-1:0] drive_right
);
  localparam int W = lqr_pkg::DATA_W;
  localparam int AW = lqr_pkg::ACC_W;
  localparam int PW = lqr_pkg::PROD_W;

  logic signed [W-1:0] gains [6];
  logic [lqr_pkg::PSEC_W-1:0] period_seconds;
  logic [lqr_pkg::PREC_W-1:0] period_reciprocal;

  logic signed [W-1:0] displacement_sum, heading_sum, previous_heading_error;
  lqr_pkg::sample_t smp;
  logic signed [W-1:0] spd, herr, deriv;
  logic signed [W-1:0] spd_sat;
  logic signed [W-1:0] heading_next;
  logic signed [W:0] spd_raw;
  logic signed [W:0] mul_a;
  logic signed [W:0] mul_b;
  logic signed [2*W+1:0] mul_full;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_l, acc_r;
  logic [2:0] tap;
  logic [3:0] pstep;
  logic [2:0] ptap;
  logic signed [PW-1:0] floored;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains[0] <= -32'sd1465;
      gains[1] <= -32'sd181331;
      gains[2] <= -32'sd900305;
      gains[3] <= -32'sd34283;
      gains[4] <= 32'sd14654;
      gains[5] <= 32'sd2119;
      period_seconds <= 17'd328;
      period_reciprocal <= 31'd13107200;
    end else if (cfg_we) begin
      if (cfg_index == lqr_pkg::REG_PERIOD_SECONDS) begin
        period_seconds <= cfg_data[lqr_pkg::PSEC_W-1:0];
      end else if (cfg_index == lqr_pkg::REG_PERIOD_RECIPROCAL) begin
        period_reciprocal <= cfg_data[lqr_pkg::PREC_W-1:0];
      end else begin
        gains[cfg_index] <= cfg_data;
      end
    end
  end

  assign status.tilt = (sample.pitch_angle > lqr_pkg::TILT_LIMIT) ||
                       (sample.pitch_angle < -lqr_pkg::TILT_LIMIT);

  assign spd_raw = (W+1)'(smp.wheel_speed) - (W+1)'(smp.speed_target);
  assign tap = 3'(cmd.step - lqr_pkg::STEP_MAC0);

  always_comb begin
    if (spd_raw > (W+1)'(lqr_pkg::SPEED_LIMIT)) spd_sat = lqr_pkg::SPEED_LIMIT;
    else if (spd_raw < -(W+1)'(lqr_pkg::SPEED_LIMIT)) spd_sat = -lqr_pkg::SPEED_LIMIT;
    else spd_sat = spd_raw[W-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      lqr_pkg::STEP_DISP: begin
        mul_a = (W+1)'(spd_sat);
        mul_b = (W+1)'({1'b0, period_seconds});
      end
      lqr_pkg::STEP_HEAD: begin
        mul_a = (W+1)'(smp.yaw_rate);
        mul_b = (W+1)'({1'b0, period_seconds});
      end
      lqr_pkg::STEP_DERIV: begin
        mul_a = (W+1)'(lqr_pkg::sat32(AW'(herr) - AW'(previous_heading_error)));
        mul_b = (W+1)'({1'b0, period_reciprocal});
      end
      lqr_pkg::STEP_MAC0, lqr_pkg::STEP_MAC1, lqr_pkg::STEP_MAC2, lqr_pkg::STEP_MAC3,
      lqr_pkg::STEP_MAC4, lqr_pkg::STEP_MAC5: begin
        mul_a = (W+1)'(gains[tap]);
        unique case (tap)
          3'd0: mul_b = (W+1)'(displacement_sum);
          3'd1: mul_b = (W+1)'(spd);
          3'd2: mul_b = (W+1)'(smp.pitch_angle);
          3'd3: mul_b = (W+1)'(smp.pitch_rate);
          3'd4: mul_b = (W+1)'(herr);
          default: mul_b = (W+1)'(deriv);
        endcase
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Register after the multiply; the registered step (pstep) keeps each product matched to its step.
  assign floored = prod >>> lqr_pkg::FRAC_BITS;
  // The heading error step runs while the heading sum is being updated,
  // so it works from the updated sum.
  assign heading_next = lqr_pkg::sat32(AW'(heading_sum) + AW'(floored));

  always_ff @(posedge clk) begin
    prod <= mul_full[PW-1:0];
    ptap <= tap;
    if (rst) begin
      previous_heading_error <= '0;
      displacement_sum <= '0;
      heading_sum <= '0;
      pstep <= lqr_pkg::STEP_IDLE;
    end else begin
      pstep <= cmd.step;
      if (cmd.clear_sums) begin
        displacement_sum <= '0;
        heading_sum <= '0;
      end
      unique case (cmd.step)
        lqr_pkg::STEP_LOAD: if (cmd.take) smp <= sample;
        lqr_pkg::STEP_DISP: spd <= spd_sat;
        default: ;
      endcase
      unique case (pstep)
        lqr_pkg::STEP_DISP:
          displacement_sum <= lqr_pkg::sat32(AW'(displacement_sum) + AW'(floored));
        lqr_pkg::STEP_HEAD: begin
          heading_sum <= heading_next;
        end
        lqr_pkg::STEP_DERIV: begin
          deriv <= lqr_pkg::sat32(AW'(floored));
          previous_heading_error <= herr;
        end
        lqr_pkg::STEP_MAC0, lqr_pkg::STEP_MAC1, lqr_pkg::STEP_MAC2, lqr_pkg::STEP_MAC3,
        lqr_pkg::STEP_MAC4, lqr_pkg::STEP_MAC5: begin
          acc_l <= ((pstep == lqr_pkg::STEP_MAC0) ? '0 : acc_l) + AW'(prod);
          acc_r <= ((pstep == lqr_pkg::STEP_MAC0) ? '0 : acc_r) +
                   ((ptap >= 3'd4) ? -AW'(prod) : AW'(prod));
        end
        default: ;
      endcase
      if (cmd.step == lqr_pkg::STEP_HERR)
        herr <= lqr_pkg::sat32(AW'(heading_next) - AW'(smp.heading_target));
    end
  end

  function automatic logic signed [W-1:0] trunc_out(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] q;
    logic signed [AW-1:0] adj;
    adj = (a < 0) ? a + AW'((72'sd1 <<< lqr_pkg::FRAC_BITS) - 72'sd1) : a;
    q = adj >>> lqr_pkg::FRAC_BITS;
    return lqr_pkg::sat32(q);
  endfunction

  assign drive_left = trunc_out(acc_l);
  assign drive_right = trunc_out(acc_r);
endmodule

// File: src/lqr_control.sv
module lqr_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          command,
  output logic                tilt_fault,
  output logic                reset_distance,
  output logic                running,
  input  lqr_pkg::dp_status_t status,
  output lqr_pkg::dp_cmd_t    cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [3:0] step;
  logic accept;

  // A new request is taken once the previous result has left or is leaving.
  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign accept = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.take = accept;
    cmd.step = (state == S_RUN) ? step : lqr_pkg::STEP_LOAD;
    cmd.clear_sums = accept && in_op == lqr_pkg::OP_ENABLE && !running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      running <= 1'b1;
      step <= lqr_pkg::STEP_DISP;
      command <= lqr_pkg::CMD_NONE;
      tilt_fault <= 1'b0;
      reset_distance <= 1'b0;
    end else begin
      if (state == S_OUT && out_ready) state <= S_IDLE;
      if (state == S_RUN) begin
        if (step == lqr_pkg::STEP_FINISH) state <= S_WAIT;
        else step <= step + 4'd1;
      end
      if (state == S_WAIT) state <= S_OUT;
      if (accept) begin
        command <= lqr_pkg::CMD_NONE;
        tilt_fault <= 1'b0;
        reset_distance <= 1'b0;
        state <= S_OUT;
        unique case (in_op)
          lqr_pkg::OP_SAMPLE: begin
            if (!running) begin
              command <= lqr_pkg::CMD_STOP;
            end else if (status.tilt) begin
              command <= lqr_pkg::CMD_STOP;
              tilt_fault <= 1'b1;
              running <= 1'b0;
            end else begin
              command <= lqr_pkg::CMD_APPLY;
              step <= lqr_pkg::STEP_DISP;
              state <= S_RUN;
            end
          end
          lqr_pkg::OP_ENABLE: begin
            reset_distance <= !running;
            running <= 1'b1;
          end
          lqr_pkg::OP_DISABLE: running <= 1'b0;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: src/lqr_balance_controller.sv
// Channel   Dir  Carries
// sample    in   op and six sensor/target words
// result    out  command, drive_left, drive_right, tilt_fault, reset_distance
// cfg       in   register index and write data
// A control sample's result is valid once the datapath has run all its steps:
// one shared 33x33 multiplier does the two integrations, the derivative and six
// gain products in turn, with a register after it. Other requests go straight to the result.
// Synchronous active-high reset restores the gains, periods and enabled state.
// A held result blocks new requests until it is taken.
module lqr_balance_controller (
  input logic clk,
  input logic rst,
  lqr_sample_if.sink sample,
  lqr_result_if.source result,
  lqr_cfg_if.sink cfg
);
  lqr_pkg::dp_cmd_t cmd;
  lqr_pkg::dp_status_t status;
  logic running;
  logic [1:0] command;
  logic tilt_fault, reset_distance;
  logic signed [lqr_pkg::DATA_W-1:0] drive_left, drive_right;

  assign cfg.ready = 1'b1;

  lqr_control u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(sample.valid), .in_op(sample.payload.op), .in_ready(sample.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .command(command), .tilt_fault(tilt_fault), .reset_distance(reset_distance),
    .running(running), .status(status), .cmd(cmd)
  );

  lqr_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .sample(sample.payload), .cmd(cmd), .status(status),
    .drive_left(drive_left), .drive_right(drive_right)
  );

  always_comb begin
    result.payload.command = command;
    result.payload.tilt_fault = tilt_fault;
    result.payload.reset_distance = reset_distance;
    result.payload.drive_left = (command == lqr_pkg::CMD_APPLY) ? drive_left : '0;
    result.payload.drive_right = (command == lqr_pkg::CMD_APPLY) ? drive_right : '0;
  end

  a_fault_stop: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.tilt_fault |-> result.payload.command == lqr_pkg::CMD_STOP)
    else $error("tilt fault without stop");
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.tilt_fault |-> !running)
    else $error("tilt fault left controller running");
  a_rdist: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.reset_distance |-> running)
    else $error("reset_distance while disabled");
endmodule
